[sv/w512_pkg.sv]
// Shared types and constants for the WELL512 random generator unit.
package w512_pkg;

  localparam int unsigned POOL_DEPTH  = 16;
  localparam int unsigned POOL_AW     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  localparam logic [31:0] TEMPER_MASK = 32'hda44_2d24;
  localparam logic [14:0] UNIT_MULT   = 15'd16807;
  localparam logic [31:0] MANT_MASK   = 32'h007f_ffff;
  localparam logic [31:0] ONE_BITS    = 32'h3f80_0000;

  // Pool taps relative to the current index
  localparam logic [POOL_AW-1:0] OFS_C    = 4'd13;
  localparam logic [POOL_AW-1:0] OFS_M    = 4'd9;
  localparam logic [POOL_AW-1:0] OFS_NEXT = 4'd15;

  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_RANGE  = 2'd1,
    OP_UNIT   = 2'd2,
    OP_RESEED = 2'd3
  } w512_op_e;

  typedef struct packed {
    w512_op_e    op;
    logic [31:0] seed;
    logic [31:0] low;
    logic [31:0] span;
    logic        span_zero;
  } w512_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_GEN,
    ST_WB,
    ST_MUL,
    ST_PREP,
    ST_NORM,
    ST_MOD,
    ST_SEED,
    ST_DONE
  } w512_state_e;

endpackage

[sv/w512_front.sv]
// Front end: accepts commands, decodes them and holds them in a short queue.
module w512_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          cmd_i,
  input  logic [31:0]         seed_i,
  input  logic [31:0]         range_low_i,
  input  logic [31:0]         range_high_i,
  output logic                item_valid_o,
  input  logic                item_pop_i,
  output w512_pkg::w512_item_t item_o
);
  import w512_pkg::*;

  w512_item_t           ent_q [QUEUE_DEPTH];
  w512_item_t           ent_d;
  logic [QUEUE_AW-1:0]  wptr_q, rptr_q;
  logic [QUEUE_AW:0]    cnt_q;
  logic                 push_ok, pop_ok;
  logic [31:0]          span;

  assign full_o       = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign push_ok      = push_i && !full_o;
  assign pop_ok       = item_pop_i && item_valid_o;
  assign item_o       = ent_q[rptr_q];

  // Decode the command and precompute the range span
  always_comb begin
    span           = range_high_i - range_low_i;
    ent_d.seed     = seed_i;
    ent_d.low      = range_low_i;
    ent_d.span     = span;
    ent_d.span_zero = (span == '0);
    ent_d.op       = w512_op_e'(cmd_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) ent_q[wptr_q] <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_ok) wptr_q <= wptr_q + 1'b1;
      if (pop_ok)  rptr_q <= rptr_q + 1'b1;
      unique case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/w512_modu.sv]
// Iterative 32-bit remainder unit, one quotient bit per cycle.
module w512_modu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  import w512_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, dvd_q, div_q;
  logic [32:0] trial, diff;

  assign trial  = {rem_q, dvd_q[31]};
  assign diff   = trial - {1'b0, div_q};
  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= diff[32] ? trial[31:0] : diff[31:0];
      dvd_q <= {dvd_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/w512_core.sv]
// Back end: pool memory, WELL512 step, range, unit float and reseed sequencing.
module w512_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         seed_step_i,
  input  logic                item_valid_i,
  input  w512_pkg::w512_item_t item_i,
  output logic                item_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [31:0]         value_o,
  output logic                range_error_o
);
  import w512_pkg::*;

  w512_state_e state_q, state_d;

  logic [31:0]            mem_q [POOL_DEPTH];
  logic [POOL_DEPTH-1:0]  vld_q;
  logic [31:0]            rd0_q, rd1_q;
  logic                   rd0_vld_q, rd1_vld_q;
  logic [POOL_AW-1:0]     idx_q, cnt_q, ra0, ra1, wa;
  logic                   we;
  logic [31:0]            wd;

  w512_op_e    op_q;
  logic [31:0] low_q, span_q, seed_q, word_q, b_q, prod_q, pend_val_q, out_val_q;
  logic        span_zero_q, pend_err_q, out_err_q, out_vld_q;
  logic [23:0] x_q;
  logic [7:0]  exp_q;

  logic [31:0] a_w, c_w, b_w, cm_w, newa_w, d_w, out_w, mant32;
  logic [22:0] mant;
  logic        slot_free, mod_start, mod_done;
  logic [31:0] mod_rem;

  w512_modu u_modu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (word_q),
    .divisor_i  (span_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Unwritten entries read as zero
  always_comb begin
    a_w    = rd0_vld_q ? rd0_q : '0;
    c_w    = rd1_vld_q ? rd1_q : '0;
    b_w    = a_w ^ c_w ^ (a_w << 16) ^ (c_w << 15);
    cm_w   = a_w ^ (a_w >> 11);
    newa_w = b_q ^ cm_w;
    d_w    = newa_w ^ ((newa_w << 5) & TEMPER_MASK);
    out_w  = c_w ^ b_q ^ d_w ^ (c_w << 2) ^ (b_q << 18) ^ (cm_w << 28);
    mant32 = prod_q & MANT_MASK;
    mant   = mant32[22:0];
  end

  assign slot_free     = !out_vld_q || pop_i;
  assign empty_o       = !out_vld_q;
  assign value_o       = out_val_q;
  assign range_error_o = out_err_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) state_d = (item_i.op == OP_RESEED) ? ST_SEED : ST_RD1;
      end
      ST_RD1: state_d = ST_RD2;
      ST_RD2: state_d = ST_GEN;
      ST_GEN: state_d = ST_WB;
      ST_WB: begin
        unique case (op_q)
          OP_RANGE: state_d = span_zero_q ? ST_DONE : ST_MOD;
          OP_UNIT:  state_d = ST_MUL;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_MUL:  state_d = ST_PREP;
      ST_PREP: state_d = (mant[22:1] == '0) ? ST_DONE : ST_NORM;
      ST_NORM: if (x_q[23]) state_d = ST_DONE;
      ST_MOD:  if (mod_done) state_d = ST_DONE;
      ST_SEED: if (cnt_q == POOL_AW'(POOL_DEPTH-1)) state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o = 1'b0;
    ra0        = idx_q;
    ra1        = idx_q + OFS_C;
    we         = 1'b0;
    wa         = idx_q;
    wd         = word_q;
    mod_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: item_pop_o = item_valid_i;
      ST_RD2: begin
        ra0 = idx_q + OFS_M;
        ra1 = idx_q + OFS_NEXT;
      end
      ST_GEN: begin
        we = 1'b1;
        wd = newa_w;
      end
      ST_WB: begin
        we        = 1'b1;
        mod_start = (op_q == OP_RANGE) && !span_zero_q;
      end
      ST_SEED: begin
        we = 1'b1;
        wa = cnt_q;
        wd = seed_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd0_q     <= mem_q[ra0];
    rd1_q     <= mem_q[ra1];
    rd0_vld_q <= vld_q[ra0];
    rd1_vld_q <= vld_q[ra1];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          op_q        <= item_i.op;
          low_q       <= item_i.low;
          span_q      <= item_i.span;
          span_zero_q <= item_i.span_zero;
          seed_q      <= item_i.seed;
        end
      end
      ST_RD2: b_q    <= b_w;
      ST_GEN: word_q <= out_w;
      ST_WB: begin
        pend_val_q <= (op_q == OP_RANGE) ? low_q : word_q;
        pend_err_q <= (op_q == OP_RANGE) && span_zero_q;
      end
      ST_MUL: prod_q <= word_q * {17'd0, UNIT_MULT};
      ST_PREP: begin
        x_q        <= {1'b0, mant - 23'd1};
        exp_q      <= ONE_BITS[30:23];
        pend_val_q <= '0;
        pend_err_q <= 1'b0;
      end
      ST_NORM: begin
        if (x_q[23]) begin
          pend_val_q <= {1'b0, exp_q, x_q[22:0]};
        end else begin
          x_q   <= {x_q[22:0], 1'b0};
          exp_q <= exp_q - 8'd1;
        end
      end
      ST_MOD: if (mod_done) pend_val_q <= low_q + mod_rem;
      ST_SEED: begin
        seed_q     <= seed_q + seed_q + seed_step_i;
        pend_val_q <= '0;
        pend_err_q <= 1'b0;
      end
      default: ;
    endcase
    if (state_q == ST_DONE && slot_free) begin
      out_val_q <= pend_val_q;
      out_err_q <= pend_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) vld_q[wa] <= 1'b1;
      if (state_q == ST_IDLE) cnt_q <= '0;
      else if (state_q == ST_SEED) cnt_q <= cnt_q + 1'b1;
      if (state_q == ST_GEN) idx_q <= idx_q + OFS_NEXT;
      else if (state_q == ST_SEED && cnt_q == POOL_AW'(POOL_DEPTH-1)) idx_q <= '0;
      if (state_q == ST_DONE && slot_free) out_vld_q <= 1'b1;
      else if (pop_i) out_vld_q <= 1'b0;
    end
  end

endmodule

[sv/well512_random_generator_unit.sv]
// Top level of the WELL512 random generator unit.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  command   | push / full        | cmd_i, seed_i, range_low_i, range_high_i
//  result    | empty / pop        | value_o, range_error_o
//  config    | cfg_we_i           | cfg_wdata_i (seed_step)
//
// One command at a time runs in the back end; a two-entry command queue and
// the result register let either side stall without stopping the other.
// After a command leaves the queue, a bounded command with unequal bounds runs
// a bit-serial remainder, a unit command normalizes with one shift per cycle,
// and a reseed writes one pool word per cycle. The pool is a 16-entry
// memory with two registered read ports and one write port; each WELL512
// step reads in ST_RD1 and ST_RD2 and writes in ST_GEN and ST_WB.
// Reset clears the pool valid bits, so the pool reads as all zero until
// written, and clears seed_step, the index and both queues at once.
module well512_random_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] seed_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_o,
  output logic        range_error_o
);
  import w512_pkg::*;

  logic [31:0] seed_step_q;
  logic        item_valid, item_pop;
  w512_item_t  item;

  // Hold the seed step; write it only while no command is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_step_q <= '0;
    end else if (cfg_we_i) begin
      seed_step_q <= cfg_wdata_i;
    end
  end

  // Decode and queue commands
  w512_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .cmd_i        (cmd_i),
    .seed_i       (seed_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  // Execute commands and present each result until its transfer
  w512_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_step_i   (seed_step_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .value_o       (value_o),
    .range_error_o (range_error_o)
  );

endmodule

[tb/tb_well512_random_generator_unit.sv]
// Self-checking testbench for the WELL512 random generator unit.
module tb_well512_random_generator_unit;
  import w512_pkg::*;

  // Pacing of the two sides; each random phase runs under one of these
  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_e;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } gen_result_t;

  // One row of the directed table; fixed_exp marks a result typed in by hand
  typedef struct packed {
    w512_op_e    op;
    logic [31:0] seed;
    logic [31:0] low;
    logic [31:0] high;
    logic        fixed_exp;
    logic [31:0] value;
    logic        err;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int SETTLE_CYCLES = 40;    // longest command (bounded) plus margin
  localparam int LONG_HOLD     = 400;

  // Zero pool first: every word is zero, so the early results are known by eye.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_RAW,    32'h0,        32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
    '{OP_RANGE,  32'h0,        32'd5,        32'd10,       1'b1, 32'd5,        1'b0},
    '{OP_RANGE,  32'h0,        32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1},
    '{OP_UNIT,   32'h0,        32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
    '{OP_RESEED, 32'h0,        32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
    '{OP_RAW,    32'h0,        32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
    '{OP_RESEED, 32'hffff_ffff, 32'h0,       32'h0,        1'b1, 32'h0,        1'b0},
    '{OP_RAW,    32'h0,        32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
    '{OP_RANGE,  32'h0,        32'h0,        32'hffff_ffff, 1'b0, 32'h0,       1'b0},
    '{OP_RANGE,  32'h0,        32'hffff_ffff, 32'h0,       1'b1, 32'hffff_ffff, 1'b0},
    '{OP_RANGE,  32'h0,        32'h0,        32'h0,        1'b1, 32'h0,        1'b1},
    '{OP_RANGE,  32'h0,        32'd100,      32'd50,       1'b0, 32'h0,        1'b0},
    '{OP_RANGE,  32'h0,        32'h0,        32'h1,        1'b1, 32'h0,        1'b0},
    '{OP_UNIT,   32'h0,        32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
    '{OP_UNIT,   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0,     1'b0},
    '{OP_RESEED, 32'h1234_5678, 32'h0,       32'h0,        1'b1, 32'h0,        1'b0},
    '{OP_RAW,    32'h0,        32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
    '{OP_RANGE,  32'h0,        32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0,      1'b0},
    '{OP_UNIT,   32'h0,        32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
    '{OP_RANGE,  32'haaaa_aaaa, 32'd1000,    32'd1000,     1'b1, 32'd1000,     1'b1},
    '{OP_RAW,    32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0,     1'b0},
    '{OP_RESEED, 32'h8000_0000, 32'h0,       32'h0,        1'b1, 32'h0,        1'b0},
    '{OP_UNIT,   32'h0,        32'h0,        32'h0,        1'b0, 32'h0,        1'b0}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        push          = 1'b0;
  logic        full;
  logic [1:0]  cmd_i         = '0;
  logic [31:0] seed_i        = '0;
  logic [31:0] range_low_i   = '0;
  logic [31:0] range_high_i  = '0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [31:0] value_o;
  logic        range_error_o;

  // Shadow of the generator state, advanced at each accepted command
  logic [31:0] pool_shadow [POOL_DEPTH];
  logic [3:0]  pool_ptr;
  logic [31:0] step_shadow;

  gen_result_t pending_results [$];
  pace_e       pace = PACE_FULL;
  int          recv_hold_req = 0;
  int          hold_left = 0;
  int          fail_count = 0;

  well512_random_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .cmd_i         (cmd_i),
    .seed_i        (seed_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .empty         (empty),
    .pop           (pop),
    .value_o       (value_o),
    .range_error_o (range_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // One WELL512 step on the shadow pool; returns the word produced
  function automatic logic [31:0] well512_next();
    logic [3:0]  idx;
    logic [31:0] a, b, c, d;
    idx = pool_ptr;
    a = pool_shadow[idx];
    c = pool_shadow[idx + OFS_C];
    b = a ^ c ^ (a << 16) ^ (c << 15);
    c = pool_shadow[idx + OFS_M];
    c = c ^ (c >> 11);
    a = b ^ c;
    pool_shadow[idx] = a;
    d = a ^ ((a << 5) & TEMPER_MASK);
    idx = idx + OFS_NEXT;
    pool_ptr = idx;
    a = pool_shadow[idx];
    pool_shadow[idx] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
    return pool_shadow[idx];
  endfunction

  // Single-precision bits of (m - 1) / 2^23; zero mantissa and m == 1 give 0.0
  function automatic logic [31:0] unit_float_bits(input logic [31:0] word);
    logic [31:0] scaled, frac;
    int          top;
    scaled = word * 32'd16807;
    frac   = scaled & MANT_MASK;
    top    = 0;
    if (frac == 32'd0 || frac == 32'd1) return 32'd0;
    frac = frac - 32'd1;
    for (int k = 0; k < 23; k++) begin
      if (frac[k]) top = k;
    end
    return ((32'd104 + 32'(top)) << 23) | ((frac << (23 - top)) & MANT_MASK);
  endfunction

  // Expected result of one command; advances the shadow state
  function automatic gen_result_t well512_predict(input w512_op_e op, input logic [31:0] seed,
                                                  input logic [31:0] low, input logic [31:0] high);
    gen_result_t res;
    logic [31:0] word, span, s;
    res  = '0;
    span = high - low;
    case (op)
      OP_RAW:    res.value = well512_next();
      OP_RANGE: begin
        word = well512_next();
        if (span == 32'd0) begin
          res.value = low;
          res.err   = 1'b1;
        end else begin
          res.value = low + (word % span);
        end
      end
      OP_UNIT:   res.value = unit_float_bits(well512_next());
      default: begin
        s = seed;
        for (int k = 0; k < POOL_DEPTH; k++) begin
          pool_shadow[k] = s;
          s = s + s + step_shadow;
        end
        pool_ptr = '0;
      end
    endcase
    return res;
  endfunction

  function automatic bit roll_idle(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Offer one command; called and returns at a falling edge
  task automatic issue(input w512_op_e op, input logic [31:0] seed, input logic [31:0] low,
                       input logic [31:0] high, input bit fixed_exp, input gen_result_t fixed_res);
    gen_result_t res;
    while ((pace == PACE_SEND_GAPS && roll_idle(57)) || (pace == PACE_BOTH && roll_idle(25)))
    begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    cmd_i        <= op;
    seed_i       <= seed;
    range_low_i  <= low;
    range_high_i <= high;
    do @(posedge clk_i); while (full);
    // Transfer taken at this edge: predict before the result can show up
    res = well512_predict(op, seed, low, high);
    pending_results.push_back(fixed_exp ? fixed_res : res);
    @(negedge clk_i);
  endtask

  task automatic issue_random();
    w512_op_e    op;
    logic [31:0] seed, low, high;
    int          pick;
    pick = $urandom_range(99);
    seed = $urandom;
    low  = $urandom;
    high = $urandom;
    if (pick < 35) begin
      op = OP_RAW;
    end else if (pick < 70) begin
      op = OP_RANGE;
      case ($urandom_range(3))
        0: high = low;
        1: high = low + 32'($urandom_range(1, 16));
        2: ;
        default: low = 32'($urandom_range(255));
      endcase
    end else if (pick < 90) begin
      op = OP_UNIT;
    end else begin
      op = OP_RESEED;
      if ($urandom_range(7) == 0) seed = '0;  // zero seed: the pool is all zero only while seed_step is zero
    end
    issue(op, seed, low, high, 1'b0, '0);
  endtask

  // Stop offering and hold until every expected result has been taken
  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write seed_step; only called with the block idle, at a falling edge
  task automatic write_seed_step(input logic [31:0] step);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= step;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    step_shadow = step;
    @(negedge clk_i);
  endtask

  // Receiver: stall per the current pace, or hold off for a long stretch on request
  always @(negedge clk_i) begin
    if (recv_hold_req > 0) begin
      hold_left = recv_hold_req;
      recv_hold_req = 0;
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (pace == PACE_RECV_STALLS) begin
      pop <= !roll_idle(57);
    end else if (pace == PACE_BOTH) begin
      pop <= !roll_idle(25);
    end else begin
      pop <= 1'b1;
    end
  end

  // Result checker: compare each transfer against the oldest expectation
  always @(posedge clk_i) begin
    gen_result_t exp_res;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result value=%h range_error=%b", value_o, range_error_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (value_o !== exp_res.value || range_error_o !== exp_res.err) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: value exp=%h act=%h, range_error exp=%b act=%b",
                     exp_res.value, value_o, exp_res.err, range_error_o);
        end
      end
    end
  end

  initial begin
    logic [31:0] step;
    // Shadow state after reset: zero pool, zero index, zero seed_step
    for (int k = 0; k < POOL_DEPTH; k++) pool_shadow[k] = '0;
    pool_ptr    = '0;
    step_shadow = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table at full rate
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      issue(DIRECTED[r].op, DIRECTED[r].seed, DIRECTED[r].low, DIRECTED[r].high,
            DIRECTED[r].fixed_exp, '{DIRECTED[r].value, DIRECTED[r].err});
    end

    // Random phases: new seed_step at idle, then a reseed so it takes effect
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: step = 32'hffff_ffff;
        1: step = 32'h0;
        3: step = 32'h1;
        4: step = 32'h8000_0000;
        6: step = 32'h7fff_ffff;
        default: step = $urandom;
      endcase
      pace = pace_e'(ph % 4);
      write_seed_step(step);
      issue(OP_RESEED, $urandom, $urandom, $urandom, 1'b0, '0);
      // Starve the output while commands keep coming, so the input backs up
      if (ph == 4) recv_hold_req = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue_random();
        // Let the block run dry once in mid-phase
        if (ph == 2 && n == PHASE_ITEMS / 2) drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
